FILE: src/bht_pkg.sv
// Shared types, codes and helpers for the bucketed hash table.
package bht_pkg;

   localparam int KEY_W          = 32;
   localparam int VAL_W          = 32;
   localparam int DEF_BUCKET_CNT = 256;
   localparam int DEF_SLOTS      = 8;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [VAL_W-1:0] found_value;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_wr;    // clear one bucket's valid marks
      logic load;      // take the request transfer
      logic mod_step;  // one remainder step
      logic rd_issue;  // read bucket at computed index
      logic commit;    // compare, write back, load result
   } bht_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic mod_last;
      logic rsp_free;
   } bht_stat_type;

   function automatic bit is_pow2(input int unsigned n);
      return (n != 0) && ((n & (n - 1)) == 0);
   endfunction

endpackage

FILE: src/bht_ctrl.sv
// Sequencing state machine for the bucketed hash table.
module bht_ctrl #(
   parameter int BUCKET_COUNT = bht_pkg::DEF_BUCKET_CNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bht_pkg::bht_stat_type stat,
   output bht_pkg::bht_cmd_type  cmd
);

   localparam bit POW2 = bht_pkg::is_pow2(BUCKET_COUNT);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_MOD  = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_CMP  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = POW2 ? S_CMP : S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) state_in = S_READ;
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_CMP;
         end
         S_CMP: begin
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

FILE: src/bht_dpath.sv
// Bucket memory, remainder unit, slot compare and result register.
module bht_dpath #(
   parameter int BUCKET_COUNT     = bht_pkg::DEF_BUCKET_CNT,
   parameter int SLOTS_PER_BUCKET = bht_pkg::DEF_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bht_pkg::bht_cmd_type  cmd,
   output bht_pkg::bht_stat_type stat,
   input  bht_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bht_pkg::rsp_type      rsp_data
);

   localparam int  S    = SLOTS_PER_BUCKET;
   localparam int  AW   = $clog2(BUCKET_COUNT);
   localparam int  KW   = bht_pkg::KEY_W;
   localparam int  VW   = bht_pkg::VAL_W;
   localparam bit  POW2 = bht_pkg::is_pow2(BUCKET_COUNT);
   localparam logic [AW-1:0] LAST_ROW = AW'(BUCKET_COUNT - 1);

   // bucket rows
   logic [S-1:0]         vld_mem [BUCKET_COUNT];
   logic [S-1:0][KW-1:0] key_mem [BUCKET_COUNT];
   logic [S-1:0][VW-1:0] val_mem [BUCKET_COUNT];

   logic [S-1:0]         rd_vld_ff;
   logic [S-1:0][KW-1:0] rd_key_ff;
   logic [S-1:0][VW-1:0] rd_val_ff;

   logic [1:0]    cmd_ff;
   logic [KW-1:0] key_ff;
   logic [VW-1:0] value_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] rd_addr, row_idx, wr_addr;
   logic          rd_en;

   logic          rsp_valid_ff;
   bht_pkg::rsp_type rsp_ff, rsp_in;

   // compare results
   logic [S-1:0]         hit_vec, hit_oh, free_oh, new_vld;
   logic [S-1:0][KW-1:0] new_key;
   logic [S-1:0][VW-1:0] new_val;
   logic [VW-1:0]        hit_val;
   logic                 vld_wr, kv_wr;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_data.cmd;
         key_ff   <= req_data.key;
         value_ff <= req_data.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign stat.clr_last = (clr_ff == LAST_ROW);

   generate
      if (POW2) begin : g_mask
         // bucket is the low key bits; read straight off the request
         assign rd_addr       = req_data.key[AW-1:0];
         assign row_idx       = key_ff[AW-1:0];
         assign rd_en         = cmd.load;
         assign stat.mod_last = 1'b1;
      end else begin : g_rem
         // reciprocal multiply: quotient = (key * MULT) >> (KW + AW) is exact
         // for every key with MULT = ceil(2^(KW+AW) / BUCKET_COUNT)
         localparam int HW    = KW / 2;
         localparam int MW    = KW + 1;
         localparam int PW    = HW + MW;
         localparam int ACC_W = KW + MW;
         localparam logic [MW-1:0] MULT = MW'(((64'd1 << (KW + AW))
                                             + 64'(BUCKET_COUNT) - 64'd1)
                                             / 64'(BUCKET_COUNT));
         localparam logic [1:0] STEP_LO  = 2'd0;
         localparam logic [1:0] STEP_HI  = 2'd1;
         localparam logic [1:0] STEP_REM = 2'd2;
         logic [ACC_W-1:0] acc_ff;
         logic [AW-1:0]    rem_ff;
         logic [1:0]       cnt_ff;
         logic [PW-1:0]    prod_lo, prod_hi;
         logic [MW-AW-1:0] quo;
         logic [KW-1:0]    quo_mul;

         // half-key partial products, one per step
         assign prod_lo = PW'(key_ff[HW-1:0]) * PW'(MULT);
         assign prod_hi = PW'(key_ff[KW-1:HW]) * PW'(MULT);
         assign quo     = acc_ff[ACC_W-1:KW+AW];
         assign quo_mul = KW'(quo) * KW'(BUCKET_COUNT);

         always_ff @(posedge clock) begin
            if (cmd.load) begin
               cnt_ff <= STEP_LO;
            end else if (cmd.mod_step) begin
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == STEP_LO) begin
                  acc_ff <= ACC_W'(prod_lo);
               end else if (cnt_ff == STEP_HI) begin
                  acc_ff <= acc_ff + {prod_hi, {HW{1'b0}}};
               end else begin
                  // remainder is below 2^AW, so the low bits suffice
                  rem_ff <= key_ff[AW-1:0] - quo_mul[AW-1:0];
               end
            end
         end

         assign stat.mod_last = (cnt_ff == STEP_REM);
         assign rd_addr       = rem_ff;
         assign row_idx       = rem_ff;
         assign rd_en         = cmd.rd_issue;
      end
   endgenerate

   assign wr_addr = cmd.clr_wr ? clr_ff : row_idx;

   always_ff @(posedge clock) begin
      if (cmd.clr_wr || (cmd.commit && vld_wr)) begin
         vld_mem[wr_addr] <= cmd.clr_wr ? '0 : new_vld;
      end
      if (cmd.commit && kv_wr) begin
         key_mem[wr_addr] <= new_key;
         val_mem[wr_addr] <= new_val;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_vld_ff <= vld_mem[rd_addr];
         rd_key_ff <= key_mem[rd_addr];
         rd_val_ff <= val_mem[rd_addr];
      end
   end

   // parallel slot compare
   always_comb begin
      hit_val = '0;
      for (int s = 0; s < S; s++) begin
         hit_vec[s] = rd_vld_ff[s] && (rd_key_ff[s] == key_ff);
      end
      hit_oh  = hit_vec & (~hit_vec + S'(1));
      free_oh = ~rd_vld_ff & (rd_vld_ff + S'(1));
      for (int s = 0; s < S; s++) begin
         hit_val    = hit_val | (hit_oh[s] ? rd_val_ff[s] : '0);
         new_key[s] = free_oh[s] ? key_ff   : rd_key_ff[s];
         new_val[s] = free_oh[s] ? value_ff : rd_val_ff[s];
      end

      new_vld            = rd_vld_ff;
      vld_wr             = 1'b0;
      kv_wr              = 1'b0;
      rsp_in.status      = bht_pkg::ST_OK;
      rsp_in.found_value = '0;
      case (cmd_ff)
         bht_pkg::CMD_INSERT: begin
            if (|hit_vec) begin
               rsp_in.status = bht_pkg::ST_DUP;
            end else if (&rd_vld_ff) begin
               rsp_in.status = bht_pkg::ST_FULL;
            end else begin
               new_vld = rd_vld_ff | free_oh;
               vld_wr  = 1'b1;
               kv_wr   = 1'b1;
            end
         end
         bht_pkg::CMD_FIND: begin
            if (|hit_vec) rsp_in.found_value = hit_val;
            else          rsp_in.status      = bht_pkg::ST_MISS;
         end
         bht_pkg::CMD_DELETE: begin
            if (|hit_vec) begin
               new_vld = rd_vld_ff & ~hit_oh;
               vld_wr  = 1'b1;
            end else begin
               rsp_in.status = bht_pkg::ST_MISS;
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

FILE: src/bucketed_hash_table.sv
// Top level of the bucketed key-value table.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_data  (cmd, key, value)
//   rsp_      out        rsp_valid/rsp_stall   rsp_data  (status, found_value)
//
// Flow: one item at a time. With a power-of-two bucket count the accept
//   cycle reads the whole bucket row; the compare state then checks all
//   slots and writes the row back when it changes. Otherwise the bucket index
//   comes from a reciprocal-multiply remainder unit (low partial product, high
//   partial product, remainder), then a read state and the compare state.
// Reset: synchronous. A clearing pass then zeroes every bucket's valid marks,
//   one row per cycle, with req_stall held high.
// Stalls: a finished result sits in the output register; the next transfer
//   is accepted meanwhile and only its compare waits for the register.
module bucketed_hash_table #(
   parameter int BUCKET_COUNT     = bht_pkg::DEF_BUCKET_CNT,
   parameter int SLOTS_PER_BUCKET = bht_pkg::DEF_SLOTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bht_pkg::rsp_type rsp_data
);

   bht_pkg::bht_cmd_type  cmd;
   bht_pkg::bht_stat_type stat;

   // sequencing: clear pass, accept, remainder steps, read, compare
   bht_ctrl #(
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   // bucket memory, slot compare, result register
   bht_dpath #(
      .BUCKET_COUNT    (BUCKET_COUNT),
      .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // one item in flight: a transfer closes the input until its result is built
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while an item is in flight");

   // the controller never commits over a result that is still held
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten");

   // controller issues at most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_wr, cmd.load, cmd.mod_step, cmd.rd_issue, cmd.commit}))
      else $error("conflicting datapath commands");

   // found_value is only nonzero with an ok status
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != bht_pkg::ST_OK) |-> rsp_data.found_value == '0)
      else $error("value returned with a failing status");

endmodule
